// ----- rtl/meter_readout_line_parser_defines.svh -----
// Assertion macros used by the meter readout line parser RTL.
`ifndef METER_READOUT_LINE_PARSER_DEFINES_SVH
`define METER_READOUT_LINE_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRLP_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("meter readout parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define MRLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("meter readout parser check failed");

`endif

// ----- rtl/mrlp_pkg.sv -----
// Types, constants and code table of the meter readout line parser.
`timescale 1ns / 1ps

package mrlp_pkg;

  // Table size and code length.
  localparam int TABLE_ENTRIES = 17;
  localparam int CODE_CHARS    = 16;
  localparam int ROM_ROWS      = 32;
  localparam int ROM_COLS      = 16;
  localparam int ID_SKIP       = 6;

  // Control characters of the readout.
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_STX   = 8'h02;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_BANG  = 8'h21;

  // Entry 0 carries the server id.
  localparam logic [4:0] ENTRY_METER_ID = 5'd0;

  typedef logic [7:0]               byte_t;
  typedef logic [4:0]               entry_t;
  typedef logic [63:0]              value_t;
  typedef logic [TABLE_ENTRIES-1:0] mask_t;

  // Code string of one table row, left aligned and padded with zero bytes.
  function automatic logic [8*ROM_COLS-1:0] code_row(input entry_t row);
    logic [8*ROM_COLS-1:0] word;
    case (row)
      5'd0:    word = {"96.1.0",    {10{8'h00}}};
      5'd1:    word = {"1.8.0",     {11{8'h00}}};
      5'd2:    word = {"2.8.0",     {11{8'h00}}};
      5'd3:    word = {"32.7.0",    {10{8'h00}}};
      5'd4:    word = {"52.7.0",    {10{8'h00}}};
      5'd5:    word = {"72.7.0",    {10{8'h00}}};
      5'd6:    word = {"31.7.0",    {10{8'h00}}};
      5'd7:    word = {"51.7.0",    {10{8'h00}}};
      5'd8:    word = {"71.7.0",    {10{8'h00}}};
      5'd9:    word = {"16.7.0",    {10{8'h00}}};
      5'd10:   word = {"14.7.0",    {10{8'h00}}};
      5'd11:   word = {"F.F",       {13{8'h00}}};
      5'd12:   word = {"1.8.00.60", {7{8'h00}}};
      5'd13:   word = {"1.8.00.61", {7{8'h00}}};
      5'd14:   word = {"1.8.00.62", {7{8'h00}}};
      5'd15:   word = {"1.8.00.63", {7{8'h00}}};
      5'd16:   word = {"1.8.00.65", {7{8'h00}}};
      default: word = '0;
    endcase
    return word;
  endfunction

  // One character of a row's code.
  function automatic byte_t code_char(input entry_t row, input logic [3:0] col);
    logic [8*ROM_COLS-1:0] word;
    word = code_row(row);
    return word[8*ROM_COLS-1 - 8*int'(col) -: 8];
  endfunction

  // Rows whose value is read in base 16; all others use base 10.
  function automatic logic is_hex_base(input entry_t row);
    return (row == 5'd0) || (row == 5'd11);
  endfunction

  // Digit value of a hex character, with a flag for a valid digit.
  function automatic logic [4:0] hex_digit(input byte_t b);
    logic [4:0] d;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = {1'b1, 4'(b - 8'h37)};
    end else begin
      d = '0;
    end
    return d;
  endfunction

endpackage

// ----- rtl/mrlp_byte_if.sv -----
// Handshake channel that carries one received readout byte per word.
`timescale 1ns / 1ps

interface mrlp_byte_if;
  logic             valid;
  logic             ready;
  mrlp_pkg::byte_t  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/mrlp_result_if.sv -----
// Handshake channel that carries one parsed reading per word.
`timescale 1ns / 1ps

interface mrlp_result_if;
  logic             valid;
  logic             ready;
  mrlp_pkg::entry_t entry_index;
  mrlp_pkg::value_t reading_value;

  modport source (output valid, output entry_index, output reading_value, input ready);
  modport sink   (input valid, input entry_index, input reading_value, output ready);
endinterface

// ----- rtl/meter_readout_line_parser.sv -----
// Meter data readout line parser: bytes in, one reading per completed line out.
//
// The block takes one byte word per cycle and works on it in a single pass:
// the byte is held in an input register, the line state (code match mask,
// value accumulator, server id) is updated by one level of logic, and a
// reading finished by a CR LF lands in the result register when the LF word
// moves on from the input register. The sustained rate is one byte per cycle,
// set by the one multiply-add step of the value accumulator per byte; it
// drops only while the result register is full and not taken.
`timescale 1ns / 1ps
`include "meter_readout_line_parser_defines.svh"

module meter_readout_line_parser (
  input  logic                 clk,
  input  logic                 rst,
  mrlp_byte_if.sink            rx,
  mrlp_result_if.source        result
);

  // Parser phase within a line.
  typedef enum logic [3:0] {
    PH_CODE   = 4'b0001,
    PH_VALUE  = 4'b0010,
    PH_STOP   = 4'b0100,
    PH_IGNORE = 4'b1000
  } phase_t;

  // Input register.
  logic             in_valid;
  mrlp_pkg::byte_t  in_byte;

  // Line state.
  phase_t           phase, phase_next;
  logic [1:0]       line_position, line_position_next;
  logic [4:0]       code_length, code_length_next;
  mrlp_pkg::mask_t  candidate_mask, candidate_mask_next;
  mrlp_pkg::entry_t matched_entry, matched_entry_next;
  mrlp_pkg::value_t value_accumulator, value_accumulator_next;
  logic [2:0]       id_skip_count, id_skip_count_next;
  logic             previous_was_cr, previous_was_cr_next;
  logic             echo_line, echo_line_next;
  mrlp_pkg::value_t stored_id, stored_id_next;

  // Result register.
  logic             out_valid;
  mrlp_pkg::entry_t out_entry;
  mrlp_pkg::value_t out_value;

  logic             advance;
  logic             line_end;
  logic             emit;
  logic [4:0]       digit;
  logic             found;
  mrlp_pkg::entry_t first_entry;

  // The held byte moves on when the result register is free or being drained.
  assign advance  = in_valid && (!out_valid || result.ready);
  assign rx.ready = !in_valid || advance;
  assign line_end = (in_byte == mrlp_pkg::CH_LF) && previous_was_cr;
  assign digit    = mrlp_pkg::hex_digit(in_byte);

  // Lowest entry still in the candidate mask.
  always_comb begin
    found       = 1'b0;
    first_entry = '0;
    for (int e = mrlp_pkg::TABLE_ENTRIES - 1; e >= 0; e--) begin
      if (candidate_mask[e]) begin
        found       = 1'b1;
        first_entry = 5'(e);
      end
    end
  end

  // Next line state for the held byte.
  always_comb begin
    phase_next             = phase;
    line_position_next     = line_position;
    code_length_next       = code_length;
    candidate_mask_next    = candidate_mask;
    matched_entry_next     = matched_entry;
    value_accumulator_next = value_accumulator;
    id_skip_count_next     = id_skip_count;
    previous_was_cr_next   = previous_was_cr;
    echo_line_next         = echo_line;
    stored_id_next         = stored_id;
    emit                   = 1'b0;

    if (line_end) begin
      // Report the finished line, then start a new one.
      if ((phase == PH_VALUE || phase == PH_STOP) && !echo_line) begin
        if (matched_entry == mrlp_pkg::ENTRY_METER_ID) begin
          if (value_accumulator != stored_id) begin
            stored_id_next = value_accumulator;
            emit           = 1'b1;
          end
        end else begin
          emit = 1'b1;
        end
      end
      previous_was_cr_next   = 1'b0;
      phase_next             = PH_CODE;
      line_position_next     = '0;
      code_length_next       = '0;
      candidate_mask_next    = '1;
      matched_entry_next     = '0;
      value_accumulator_next = '0;
      id_skip_count_next     = '0;
      echo_line_next         = 1'b0;
    end else begin
      previous_was_cr_next = (in_byte == mrlp_pkg::CH_CR);
      if (line_position == 2'd2 &&
          (in_byte == mrlp_pkg::CH_SLASH || in_byte == mrlp_pkg::CH_BANG)) begin
        echo_line_next = 1'b1;
      end
      if (line_position != 2'd3) begin
        line_position_next = line_position + 2'd1;
      end

      case (phase)
        PH_CODE: begin
          if (line_position == 2'd0 && in_byte == mrlp_pkg::CH_STX) begin
            // A leading STX is skipped.
          end else if (in_byte == mrlp_pkg::CH_OPEN) begin
            if (code_length == '0 || !found) begin
              phase_next = PH_IGNORE;
            end else begin
              matched_entry_next = first_entry;
              phase_next         = PH_VALUE;
            end
          end else if (code_length >= 5'(mrlp_pkg::CODE_CHARS)) begin
            candidate_mask_next = '0;
          end else begin
            for (int e = 0; e < mrlp_pkg::TABLE_ENTRIES; e++) begin
              if (mrlp_pkg::code_char(5'(e), code_length[3:0]) != in_byte) begin
                candidate_mask_next[e] = 1'b0;
              end
            end
            code_length_next = code_length + 5'd1;
          end
        end
        PH_VALUE: begin
          if (matched_entry == mrlp_pkg::ENTRY_METER_ID &&
              id_skip_count < 3'(mrlp_pkg::ID_SKIP)) begin
            id_skip_count_next = id_skip_count + 3'd1;
          end else if (in_byte == mrlp_pkg::CH_STAR) begin
            phase_next = PH_STOP;
          end else if (digit[4]) begin
            if (mrlp_pkg::is_hex_base(matched_entry)) begin
              value_accumulator_next = (value_accumulator << 4) + {60'd0, digit[3:0]};
            end else begin
              value_accumulator_next = (value_accumulator << 3) +
                                       (value_accumulator << 1) + {60'd0, digit[3:0]};
            end
          end
        end
        PH_STOP, PH_IGNORE: begin
          // Bytes are dropped until the line ends.
        end
        default: begin
          phase_next = PH_IGNORE;
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  // Line state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_CODE;
      line_position     <= '0;
      code_length       <= '0;
      candidate_mask    <= '1;
      matched_entry     <= '0;
      value_accumulator <= '0;
      id_skip_count     <= '0;
      previous_was_cr   <= 1'b0;
      echo_line         <= 1'b0;
      stored_id         <= '0;
    end else if (advance) begin
      phase             <= phase_next;
      line_position     <= line_position_next;
      code_length       <= code_length_next;
      candidate_mask    <= candidate_mask_next;
      matched_entry     <= matched_entry_next;
      value_accumulator <= value_accumulator_next;
      id_skip_count     <= id_skip_count_next;
      previous_was_cr   <= previous_was_cr_next;
      echo_line         <= echo_line_next;
      stored_id         <= stored_id_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && emit) begin
      out_entry <= matched_entry;
      out_value <= value_accumulator;
    end
  end

  assign result.valid         = out_valid;
  assign result.entry_index   = out_entry;
  assign result.reading_value = out_value;

  // A reported server id is the one now stored.
  `MRLP_ASSERT_SAME(a_reported_id_stored, clk, rst, out_valid && out_entry == mrlp_pkg::ENTRY_METER_ID, stored_id == out_value)
  // Reported entries lie inside the table.
  `MRLP_ASSERT_SAME(a_entry_in_table, clk, rst, out_valid, out_entry < 5'(mrlp_pkg::TABLE_ENTRIES))
  // A line end restarts code matching with every entry a candidate.
  `MRLP_ASSERT_NEXT(a_line_restart, clk, rst, advance && line_end, phase == PH_CODE && candidate_mask == '1)

endmodule

// ----- tb/sv/meter_readout_line_parser_tb.sv -----
// Self-checking testbench of the meter readout line parser: directed lines, then random readouts.
`timescale 1ns / 1ps

module meter_readout_line_parser_tb;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_BYTES  = 1170;
  localparam int SETTLE_CYCLES = 10;

  // Rows of the code list that read their value in base 16.
  localparam logic [mrlp_pkg::TABLE_ENTRIES-1:0] HEX_BASE_ROWS = 17'h00801;

  typedef enum logic [1:0] {LN_CODE, LN_VALUE, LN_STOPPED, LN_IGNORE} line_phase_t;

  typedef struct {
    mrlp_pkg::entry_t idx;
    mrlp_pkg::value_t val;
  } reading_t;

  // One directed line; want_count -1 means the predictor decides.
  typedef struct {
    string            text;
    int               want_count;
    mrlp_pkg::entry_t idx;
    mrlp_pkg::value_t val;
  } line_row_t;

  string obis_code [mrlp_pkg::TABLE_ENTRIES] = '{
    "96.1.0", "1.8.0", "2.8.0", "32.7.0", "52.7.0", "72.7.0",
    "31.7.0", "51.7.0", "71.7.0", "16.7.0", "14.7.0", "F.F",
    "1.8.00.60", "1.8.00.61", "1.8.00.62", "1.8.00.63", "1.8.00.65"
  };

  logic clk;
  logic rst;

  mrlp_byte_if   rx ();
  mrlp_result_if result ();

  meter_readout_line_parser dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .result (result)
  );

  // Predictor state of the current line and the remembered server id.
  line_phase_t      lp_phase;
  logic [7:0]       lp_pos;
  logic [4:0]       code_len;
  mrlp_pkg::mask_t  cand;
  mrlp_pkg::entry_t lp_entry;
  mrlp_pkg::value_t lp_acc;
  logic [2:0]       skip_cnt;
  logic             saw_cr;
  logic             echo_seen;
  mrlp_pkg::value_t last_id;

  reading_t         pending_readings [$];
  line_row_t        line_rows [$];
  mrlp_pkg::byte_t  line_buf [$];

  int src_idle_pct;
  int snk_idle_pct;
  int errors;
  int cycle_count;
  int bytes_sent;
  int lines_sent;
  int readings_due;
  int readings_checked;
  int id_changes;

  reading_t got_reading;
  reading_t want_reading;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side stalls at random.
  always @(negedge clk) begin
    result.ready = ($urandom_range(99) >= snk_idle_pct);
  end

  // Character of a code row, padded with zero bytes.
  function automatic mrlp_pkg::byte_t obis_char(input int e, input int col);
    if (col < obis_code[e].len()) return obis_code[e][col];
    return 8'h00;
  endfunction

  // Digit value of a hex character, -1 for anything else.
  function automatic int digit_value(input mrlp_pkg::byte_t b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b) - 48;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 87;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 55;
    return -1;
  endfunction

  function automatic void clear_line();
    lp_phase  = LN_CODE;
    lp_pos    = '0;
    code_len  = '0;
    cand      = '1;
    lp_entry  = '0;
    lp_acc    = '0;
    skip_cnt  = '0;
    echo_seen = 1'b0;
  endfunction

  // Advances the predictor by one byte; got is set when the byte ends a reported line.
  function automatic void parse_readout_byte(input mrlp_pkg::byte_t b, output logic got,
                                             output mrlp_pkg::entry_t idx,
                                             output mrlp_pkg::value_t val);
    logic [7:0] at;
    int         d;
    int         e;
    got = 1'b0;
    idx = '0;
    val = '0;
    // CR LF closes the line and may report it.
    if (b == mrlp_pkg::CH_LF && saw_cr) begin
      if ((lp_phase == LN_VALUE || lp_phase == LN_STOPPED) && !echo_seen) begin
        if (lp_entry != mrlp_pkg::ENTRY_METER_ID) begin
          got = 1'b1;
          idx = lp_entry;
          val = lp_acc;
        end else if (lp_acc != last_id) begin
          last_id = lp_acc;
          got = 1'b1;
          idx = lp_entry;
          val = lp_acc;
        end
      end
      saw_cr = 1'b0;
      clear_line();
      return;
    end
    saw_cr = (b == mrlp_pkg::CH_CR);
    at = lp_pos;
    if (at == 8'd2 && (b == mrlp_pkg::CH_SLASH || b == mrlp_pkg::CH_BANG)) echo_seen = 1'b1;
    if (lp_pos != 8'hff) lp_pos = lp_pos + 8'd1;
    case (lp_phase)
      LN_CODE: begin
        // A leading STX is dropped; '(' picks the lowest surviving entry.
        if (!(at == 8'd0 && b == mrlp_pkg::CH_STX)) begin
          if (b == mrlp_pkg::CH_OPEN) begin
            if (code_len == 0 || cand == '0) begin
              lp_phase = LN_IGNORE;
            end else begin
              for (e = mrlp_pkg::TABLE_ENTRIES - 1; e >= 0; e--) begin
                if (cand[e]) lp_entry = mrlp_pkg::entry_t'(e);
              end
              lp_phase = LN_VALUE;
            end
          end else if (code_len >= mrlp_pkg::CODE_CHARS) begin
            cand = '0;
          end else begin
            for (e = 0; e < mrlp_pkg::TABLE_ENTRIES; e++) begin
              if (obis_char(e, int'(code_len)) != b) cand[e] = 1'b0;
            end
            code_len = code_len + 5'd1;
          end
        end
      end
      LN_VALUE: begin
        // The server id drops six characters before its digits.
        d = digit_value(b);
        if (lp_entry == mrlp_pkg::ENTRY_METER_ID && skip_cnt < mrlp_pkg::ID_SKIP) begin
          skip_cnt = skip_cnt + 3'd1;
        end else if (b == mrlp_pkg::CH_STAR) begin
          lp_phase = LN_STOPPED;
        end else if (d >= 0) begin
          lp_acc = lp_acc * (HEX_BASE_ROWS[lp_entry] ? 64'd16 : 64'd10) +
                   mrlp_pkg::value_t'(d);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Sends one word, with sender gaps, and predicts its effect once accepted.
  task automatic send_byte(input mrlp_pkg::byte_t b, input logic use_model);
    logic             got;
    mrlp_pkg::entry_t idx;
    mrlp_pkg::value_t val;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      rx.valid = 1'b0;
      @(negedge clk);
    end
    rx.valid   = 1'b1;
    rx.rx_byte = b;
    do @(posedge clk); while (rx.ready !== 1'b1);
    bytes_sent++;
    parse_readout_byte(b, got, idx, val);
    if (got) begin
      readings_due++;
      if (idx == mrlp_pkg::ENTRY_METER_ID) id_changes++;
      if (use_model) begin
        got_reading.idx = idx;
        got_reading.val = val;
        pending_readings.push_back(got_reading);
      end
    end
  endtask

  // Holds the sender off until every predicted reading has come out.
  task automatic wait_for_readings();
    @(negedge clk);
    rx.valid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  function automatic void add_row(input string text, input int want_count,
                                  input mrlp_pkg::entry_t idx, input mrlp_pkg::value_t val);
    line_row_t r;
    r.text       = text;
    r.want_count = want_count;
    r.idx        = idx;
    r.val        = val;
    line_rows.push_back(r);
  endfunction

  // Directed text uses stand-ins for bytes that a literal cannot hold well.
  function automatic mrlp_pkg::byte_t expand_char(input mrlp_pkg::byte_t c);
    case (c)
      "@":     return 8'h00;
      "#":     return mrlp_pkg::CH_STX;
      "^":     return mrlp_pkg::CH_CR;
      "~":     return mrlp_pkg::CH_LF;
      default: return c;
    endcase
  endfunction

  function automatic void push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic mrlp_pkg::byte_t pick_char(input string pool);
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  // Well-formed line body without its CR LF.
  function automatic void good_body();
    string id_pool [3];
    int    e;
    int    cut;
    int    n;
    int    i;
    id_pool = '{"0A1B2C3D4E5F", "123456789", "FFFF"};
    e = $urandom_range(mrlp_pkg::TABLE_ENTRIES - 1);
    if ($urandom_range(9) == 0) line_buf.push_back(mrlp_pkg::CH_STX);
    cut = obis_code[e].len();
    if ($urandom_range(4) == 0) cut = $urandom_range(1, cut);
    for (i = 0; i < cut; i++) line_buf.push_back(obis_code[e][i]);
    line_buf.push_back(mrlp_pkg::CH_OPEN);
    if (e == 0) begin
      // Server id: a few recurring values, so both changes and repeats occur.
      if ($urandom_range(7) == 0) begin
        n = $urandom_range(5);
        for (i = 0; i < n; i++) line_buf.push_back(pick_char("0123456789ABC.-"));
      end else begin
        for (i = 0; i < mrlp_pkg::ID_SKIP; i++)
          line_buf.push_back(pick_char("0123456789ABC.-"));
        push_text(id_pool[$urandom_range(2)]);
      end
    end else begin
      n = ($urandom_range(9) == 0) ? $urandom_range(18, 30) : $urandom_range(1, 10);
      for (i = 0; i < n; i++) begin
        if (HEX_BASE_ROWS[e] || $urandom_range(9) == 0)
          line_buf.push_back(pick_char("0123456789abcdefABCDEF"));
        else if ($urandom_range(14) == 0)
          line_buf.push_back(8'h2e);
        else
          line_buf.push_back(pick_char("0123456789"));
      end
    end
    if ($urandom_range(2) != 0) begin
      line_buf.push_back(mrlp_pkg::CH_STAR);
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) line_buf.push_back(pick_char("kWhVAr0123"));
    end
    line_buf.push_back(8'h29);
  endfunction

  // Builds one random line: mostly well formed, the rest echoed, broken, noise or overlong.
  function automatic void make_line();
    int kind;
    int n;
    int i;
    line_buf.delete();
    kind = $urandom_range(99);
    if (kind < 68) begin
      good_body();
    end else if (kind < 76) begin
      // Echoed sign-on: slash or bang at the third byte.
      good_body();
      line_buf[2] = ($urandom_range(1) != 0) ? mrlp_pkg::CH_SLASH : mrlp_pkg::CH_BANG;
    end else if (kind < 84) begin
      case ($urandom_range(4))
        0: push_text("(123)");
        1: begin
          n = $urandom_range(1, 6);
          for (i = 0; i < n; i++) line_buf.push_back(pick_char("0123456789.:-ABCXYZ"));
          push_text("(5)");
        end
        2: begin
          push_text(obis_code[$urandom_range(mrlp_pkg::TABLE_ENTRIES - 1)]);
          push_text(" 12)");
        end
        3: begin
          push_text(obis_code[$urandom_range(mrlp_pkg::TABLE_ENTRIES - 1)]);
          n = $urandom_range(8, 14);
          for (i = 0; i < n; i++) line_buf.push_back(8'h00);
          push_text("(77)");
        end
        default: begin
          n = $urandom_range(1, 3);
          for (i = 0; i < n; i++) line_buf.push_back(8'h00);
          push_text("(5)");
        end
      endcase
    end else if (kind < 97) begin
      n = $urandom_range(40);
      for (i = 0; i < n; i++) line_buf.push_back(mrlp_pkg::byte_t'($urandom_range(255)));
    end else begin
      // Long line: runs the line position into saturation with echo marks in it.
      good_body();
      void'(line_buf.pop_back());
      n = $urandom_range(250, 300);
      for (i = 0; i < n; i++) line_buf.push_back(pick_char("0123456789/!*"));
      line_buf.push_back(8'h29);
    end
    line_buf.push_back(mrlp_pkg::CH_CR);
    line_buf.push_back(mrlp_pkg::CH_LF);
  endfunction

  // Compares each reading word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && result.valid === 1'b1 && result.ready === 1'b1) begin
      if (pending_readings.size() == 0) begin
        $error("unexpected reading: entry_index %0d reading_value %h",
               result.entry_index, result.reading_value);
        errors++;
      end else begin
        want_reading = pending_readings.pop_front();
        if (result.entry_index !== want_reading.idx) begin
          $error("entry_index: expected %0d, actual %0d", want_reading.idx,
                 result.entry_index);
          errors++;
        end
        if (result.reading_value !== want_reading.val) begin
          $error("reading_value: expected %h, actual %h", want_reading.val,
                 result.reading_value);
          errors++;
        end
        readings_checked++;
      end
    end
  end

  // Stimulus.
  initial begin
    int ph;
    int j;
    int goal;
    int idle_src [3];
    int idle_snk [3];
    idle_src = '{30, 71, 0};
    idle_snk = '{71, 30, 0};
    rst          = 1'b1;
    rx.valid     = 1'b0;
    rx.rx_byte   = '0;
    result.ready = 1'b0;
    src_idle_pct = idle_src[0];
    snk_idle_pct = idle_snk[0];
    clear_line();
    saw_cr  = 1'b0;
    last_id = '0;

    // Directed lines; each gets CR LF appended.
    add_row("/?!", 0, '0, '0);
    add_row("1.8.0(0000123.456*kWh)", 1, 5'd1, 64'd123456);
    add_row("#1.8.0(42)", 1, 5'd1, 64'd42);
    add_row("96.1.0(0123456789AB)", 1, mrlp_pkg::ENTRY_METER_ID, 64'h6789ab);
    add_row("96.1.0(0123456789AB)", 0, '0, '0);
    add_row("96.1.0(12)", 1, mrlp_pkg::ENTRY_METER_ID, 64'd0);
    add_row("96.1.0(ABCDEF)", 0, '0, '0);
    add_row("F.F(00FFFF)", 1, 5'd11, 64'hffff);
    add_row("F.F(FFFFFFFFFFFFFFFFF)", 1, 5'd11, 64'hffff_ffff_ffff_ffff);
    add_row("1.8.00.65(7)", 1, 5'd16, 64'd7);
    add_row("1.8.00.60(5)", 1, 5'd12, 64'd5);
    add_row("1.8.00.6(8)", -1, '0, '0);
    add_row("1(99)", 1, 5'd1, 64'd99);
    add_row("1(/5)", 0, '0, '0);
    add_row("(5)", 0, '0, '0);
    add_row("9.9.9(5)", 0, '0, '0);
    add_row("1.8.0", 0, '0, '0);
    add_row("1.8.0@@@@@@@@@@@(5)", 1, 5'd1, 64'd5);
    add_row("1.8.0@@@@@@@@@@@@(5)", 0, '0, '0);
    add_row("@(5)", 0, '0, '0);
    add_row("2.8.0(12(3)*45)", 1, 5'd2, 64'd123);
    add_row("71.7.0(5a)", 1, 5'd8, 64'd60);
    add_row("14.7.0(50.01*Hz)", 1, 5'd10, 64'd5001);
    add_row("1.8.0(1^2~3)", 1, 5'd1, 64'd123);
    add_row("1.8.0(99999999999999999999999)", -1, '0, '0);
    add_row("1.8.0(7)^", -1, '0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: typed rows push their own expectation after the LF.
    foreach (line_rows[r]) begin
      line_buf.delete();
      for (j = 0; j < line_rows[r].text.len(); j++)
        line_buf.push_back(expand_char(line_rows[r].text[j]));
      line_buf.push_back(mrlp_pkg::CH_CR);
      line_buf.push_back(mrlp_pkg::CH_LF);
      foreach (line_buf[k]) send_byte(line_buf[k], line_rows[r].want_count < 0);
      if (line_rows[r].want_count == 1) begin
        got_reading.idx = line_rows[r].idx;
        got_reading.val = line_rows[r].val;
        pending_readings.push_back(got_reading);
      end
      lines_sent++;
    end
    wait_for_readings();

    // Random part in three idling regimes, drained between them.
    goal = bytes_sent;
    for (ph = 0; ph < 3; ph++) begin
      src_idle_pct = idle_src[ph];
      snk_idle_pct = idle_snk[ph];
      while (bytes_sent < goal + RANDOM_BYTES * (ph + 1) / 3) begin
        make_line();
        foreach (line_buf[k]) send_byte(line_buf[k], 1'b1);
        lines_sent++;
      end
      wait_for_readings();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("summary: %0d bytes in %0d lines, %0d readings checked", bytes_sent,
             lines_sent, readings_checked);
    $display("summary: %0d server id changes, %0d cycles", id_changes, cycle_count);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
